// ----- design/gdda_pkg.sv -----
// Shared types, constants and calendar helper functions for the date arithmetic block.
package gdda_pkg;

    localparam int DAY_W  = 5;
    localparam int MON_W  = 4;
    localparam int YEAR_W = 14;
    localparam int ADD_W  = 16;
    localparam int DIFF_W = 22;

    localparam logic [YEAR_W-1:0] MAX_YEAR      = YEAR_W'(9999);
    localparam logic [YEAR_W-1:0] MAX_QUAD_YEAR = MAX_YEAR - YEAR_W'(4);

    localparam logic [MON_W-1:0] MONTH_JAN = MON_W'(1);
    localparam logic [MON_W-1:0] MONTH_FEB = MON_W'(2);
    localparam logic [MON_W-1:0] MONTH_DEC = MON_W'(12);
    localparam logic [DAY_W-1:0] LAST_DAY_DEC = DAY_W'(31);

    // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT, exact for x < 10400
    localparam int               RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP_100 = RECIP_W'(5243);
    localparam int               RECIP_SHIFT = 19;
    localparam int               PROD_W      = YEAR_W + RECIP_W;
    localparam int               Q_W         = 7;   // year / 100 up to 104
    localparam int               Q400_W      = Q_W - 2;
    localparam int               LEAP_W      = 12;  // leap years before year
    localparam int               CUM_W       = 9;   // days before month
    localparam int               R100_W      = 7;
    localparam int               R400_W      = 9;
    localparam int               QUAD_W      = 11;

    localparam int DAYS_PER_YEAR = 365;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        ACT_DIFF = 1'b0,
        ACT_ADD  = 1'b1
    } action_t;

    typedef struct packed {
        action_t            action;
        logic [DAY_W-1:0]   first_day;
        logic [MON_W-1:0]   first_month;
        logic [YEAR_W-1:0]  first_year;
        logic [DAY_W-1:0]   second_day;
        logic [MON_W-1:0]   second_month;
        logic [YEAR_W-1:0]  second_year;
        logic [ADD_W-1:0]   days_to_add;
    } cmd_t;

    function automatic logic [MON_W-1:0] fix_month(input logic [MON_W-1:0] m);
        logic [MON_W-1:0] r;
        if (m == '0)
            r = MONTH_JAN;
        else if (m > MONTH_DEC)
            r = MONTH_DEC;
        else
            r = m;
        return r;
    endfunction

    function automatic logic [YEAR_W-1:0] fix_year(input logic [YEAR_W-1:0] y);
        return (y > MAX_YEAR) ? MAX_YEAR : y;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] r;
        case (m)
            MON_W'(4), MON_W'(6), MON_W'(9), MON_W'(11): r = DAY_W'(30);
            MONTH_FEB: r = leap ? DAY_W'(29) : DAY_W'(28);
            default:   r = DAY_W'(31);
        endcase
        return r;
    endfunction

    // days in the months before month m
    function automatic logic [CUM_W-1:0] cum_days(input logic [MON_W-1:0] m,
                                                  input logic leap);
        logic [CUM_W-1:0] r;
        case (m)
            MON_W'(1):  r = CUM_W'(0);
            MON_W'(2):  r = CUM_W'(31);
            MON_W'(3):  r = CUM_W'(59);
            MON_W'(4):  r = CUM_W'(90);
            MON_W'(5):  r = CUM_W'(120);
            MON_W'(6):  r = CUM_W'(151);
            MON_W'(7):  r = CUM_W'(181);
            MON_W'(8):  r = CUM_W'(212);
            MON_W'(9):  r = CUM_W'(243);
            MON_W'(10): r = CUM_W'(273);
            MON_W'(11): r = CUM_W'(304);
            default:    r = CUM_W'(334);
        endcase
        if (leap && (m > MONTH_FEB))
            r = r + CUM_W'(1);
        return r;
    endfunction

endpackage

// ----- design/gdda_req_if.sv -----
// Request channel: valid/ready handshake carrying two dates, the action and a day count.
interface gdda_req_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [gdda_pkg::DAY_W-1:0]   first_day;
    logic [gdda_pkg::MON_W-1:0]   first_month;
    logic [gdda_pkg::YEAR_W-1:0]  first_year;
    logic [gdda_pkg::DAY_W-1:0]   second_day;
    logic [gdda_pkg::MON_W-1:0]   second_month;
    logic [gdda_pkg::YEAR_W-1:0]  second_year;
    logic [gdda_pkg::ADD_W-1:0]   days_to_add;

    modport source (
        output valid, action, first_day, first_month, first_year,
               second_day, second_month, second_year, days_to_add,
        input  ready
    );

    modport sink (
        input  valid, action, first_day, first_month, first_year,
               second_day, second_month, second_year, days_to_add,
        output ready
    );
endinterface

// ----- design/gdda_rsp_if.sv -----
// Response channel: valid/ready handshake carrying the day difference or the new date.
interface gdda_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [gdda_pkg::DIFF_W-1:0]  day_difference;
    logic [gdda_pkg::DAY_W-1:0]   result_day;
    logic [gdda_pkg::MON_W-1:0]   result_month;
    logic [gdda_pkg::YEAR_W-1:0]  result_year;
    logic                         year_overflow;

    modport source (
        output valid, day_difference, result_day, result_month, result_year,
               year_overflow,
        input  ready
    );

    modport sink (
        input  valid, day_difference, result_day, result_month, result_year,
               year_overflow,
        output ready
    );
endinterface

// ----- design/gregorian_date_difference_add.sv -----
// Top level of the Gregorian date difference / add-days block.
//
// Each request beat carries two dates, an action and a day count. With action
// difference the block maps both dates to day numbers counted from year 0
// (years before, months before, day of month) and returns their absolute
// difference; the date fields of the response are zero. With action add it
// moves the first date forward by days_to_add days under the Gregorian leap
// rule (year 0 is leap) and returns the new date with day_difference zero;
// if the walk passes the last year (9999) the result is pinned to 31 December
// of that year and year_overflow is set. Months outside 1..12 are clamped,
// years above 9999 are taken as 9999, and days are used as given.
// A difference runs one divide-by-100 step and one day-count step per date,
// then a subtract. An add runs one divide-by-100 step and a setup step, then
// the walk, which covers one month, one year or a four-year block per cycle.
// Requests are taken into a front stage and a two-entry queue while the back
// end works, and a finished response waits in its own register, so neither
// side stalls the other until the queue fills. There is one response beat
// per request beat.
module gregorian_date_difference_add (
    input  logic       clk,
    input  logic       rst_n,
    gdda_req_if.sink   req,
    gdda_rsp_if.source rsp
);
    import gdda_pkg::*;

    // front -> queue
    logic q_push;
    logic q_full;
    cmd_t q_push_cmd;

    // queue -> back
    logic q_pop;
    logic q_valid;
    cmd_t q_pop_cmd;

    // accept, clamp month/year, stage one command
    gdda_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .q_full (q_full),
        .q_push (q_push),
        .q_cmd  (q_push_cmd)
    );

    // decouples the front from the long add walks
    gdda_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_cmd  (q_pop_cmd)
    );

    // day counts, month walk and the response register
    gdda_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_cmd   (q_pop_cmd),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );
endmodule

// ----- design/gdda_front.sv -----
// Front end: accepts request beats, clamps month and year, and pushes commands to the queue.
module gdda_front (
    input  logic           clk,
    input  logic           rst_n,
    gdda_req_if.sink       req,
    input  logic           q_full,
    output logic           q_push,
    output gdda_pkg::cmd_t q_cmd
);
    import gdda_pkg::*;

    logic stage_valid_reg, stage_valid_next;
    cmd_t stage_reg;
    logic take;

    assign req.ready = !stage_valid_reg || !q_full;
    assign take      = req.valid && req.ready;
    assign q_push    = stage_valid_reg && !q_full;
    assign q_cmd     = stage_reg;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (take)
            stage_valid_next = 1'b1;
        else if (q_push)
            stage_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            stage_valid_reg <= 1'b0;
        else
            stage_valid_reg <= stage_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_reg.action       <= action_t'(req.action);
            stage_reg.first_day    <= req.first_day;
            stage_reg.first_month  <= fix_month(req.first_month);
            stage_reg.first_year   <= fix_year(req.first_year);
            stage_reg.second_day   <= req.second_day;
            stage_reg.second_month <= fix_month(req.second_month);
            stage_reg.second_year  <= fix_year(req.second_year);
            stage_reg.days_to_add  <= req.days_to_add;
        end
    end
endmodule

// ----- design/gdda_queue.sv -----
// Short command queue between front end and back end.
module gdda_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  gdda_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output gdda_pkg::cmd_t pop_cmd
);
    import gdda_pkg::*;

    cmd_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              do_push, do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign valid   = (count_reg != '0);
    assign pop_cmd = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_cmd;
    end
endmodule

// ----- design/gdda_back.sv -----
// Back end: sequencer for day counts and month/year walking, with the response register.
module gdda_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_valid,
    input  gdda_pkg::cmd_t q_cmd,
    output logic           q_pop,
    gdda_rsp_if.source     rsp
);
    import gdda_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_DIV  = 7'b0000010,
        ST_CNT  = 7'b0000100,
        ST_DIFF = 7'b0001000,
        ST_INIT = 7'b0010000,
        ST_WALK = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    state_t              state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic                sel_reg, sel_next;
    logic [Q_W-1:0]      qy_reg, qy_next;
    logic [Q_W-1:0]      q100_reg, q100_next;
    logic [Q400_W-1:0]   q400_reg, q400_next;
    logic [DIFF_W-1:0]   cnt_a_reg, cnt_a_next;
    logic [DIFF_W-1:0]   cnt_b_reg, cnt_b_next;
    logic [DIFF_W-1:0]   diff_reg, diff_next;
    logic [DAY_W-1:0]    d_reg, d_next;
    logic [MON_W-1:0]    m_reg, m_next;
    logic [YEAR_W-1:0]   y_reg, y_next;
    logic [ADD_W-1:0]    n_reg, n_next;
    logic [1:0]          r4_reg, r4_next;
    logic [R100_W-1:0]   r100_reg, r100_next;
    logic [R400_W-1:0]   r400_reg, r400_next;
    logic                ovf_reg, ovf_next;
    logic                rsp_valid_reg, rsp_valid_next;
    logic [DIFF_W-1:0]   out_diff_reg;
    logic [DAY_W-1:0]    out_day_reg;
    logic [MON_W-1:0]    out_mon_reg;
    logic [YEAR_W-1:0]   out_year_reg;
    logic                out_ovf_reg;
    logic                load_out;

    // date under work in the day-count path
    logic [YEAR_W-1:0]   cur_y;
    logic [MON_W-1:0]    cur_m;
    logic [DAY_W-1:0]    cur_d;

    // divide-by-100 products
    logic [YEAR_W-1:0]   x99, x399;
    logic [PROD_W-1:0]   prod_y, prod_99, prod_399;

    // day-count terms
    logic [YEAR_W-1:0]   y_plus3, y_hund, y_four_hund, y_mod100, y_mod400;
    logic [LEAP_W-1:0]   leaps;
    logic                leap_c;
    logic [DIFF_W-1:0]   count;

    // month walk terms
    logic                leap_w, at_jan1;
    logic [DAY_W-1:0]    mlen;
    logic [DAY_W:0]      steps;
    logic [QUAD_W-1:0]   year_len, quad_len;
    logic [R100_W-1:0]   r100_inc, r100_quad;
    logic [R400_W-1:0]   r400_inc, r400_quad;

    assign cur_y = sel_reg ? cmd_reg.second_year  : cmd_reg.first_year;
    assign cur_m = sel_reg ? cmd_reg.second_month : cmd_reg.first_month;
    assign cur_d = sel_reg ? cmd_reg.second_day   : cmd_reg.first_day;

    assign x99      = cur_y + YEAR_W'(99);
    assign x399     = cur_y + YEAR_W'(399);
    assign prod_y   = PROD_W'(cur_y) * PROD_W'(RECIP_100);
    assign prod_99  = PROD_W'(x99)   * PROD_W'(RECIP_100);
    assign prod_399 = PROD_W'(x399)  * PROD_W'(RECIP_100);

    // leaps before year y: ceil(y/4) - ceil(y/100) + ceil(y/400)
    assign y_plus3     = cur_y + YEAR_W'(3);
    assign leaps       = LEAP_W'(y_plus3 >> 2) - LEAP_W'(q100_reg) + LEAP_W'(q400_reg);
    assign y_hund      = YEAR_W'(qy_reg) * YEAR_W'(100);
    assign y_four_hund = YEAR_W'(qy_reg[Q_W-1:2]) * YEAR_W'(400);
    assign y_mod100    = cur_y - y_hund;
    assign y_mod400    = cur_y - y_four_hund;
    assign leap_c      = (cur_y[1:0] == 2'b00) &&
                         ((y_mod100 != '0) || (qy_reg[1:0] == 2'b00));
    assign count       = DIFF_W'(cur_y) * DIFF_W'(DAYS_PER_YEAR) + DIFF_W'(leaps)
                       + DIFF_W'(cum_days(cur_m, leap_c)) + DIFF_W'(cur_d);

    assign leap_w    = (r4_reg == 2'b00) && ((r100_reg != '0) || (r400_reg == '0));
    assign at_jan1   = (d_reg == DAY_W'(1)) && (m_reg == MONTH_JAN);
    assign mlen      = month_len(m_reg, leap_w);
    assign steps     = ((mlen > d_reg) ? {1'b0, mlen - d_reg} : '0) + (DAY_W+1)'(1);
    assign year_len  = leap_w ? QUAD_W'(366) : QUAD_W'(365);
    assign quad_len  = leap_w ? QUAD_W'(1461) : QUAD_W'(1460);
    assign r100_inc  = (r100_reg == R100_W'(99))  ? '0 : r100_reg + R100_W'(1);
    assign r400_inc  = (r400_reg == R400_W'(399)) ? '0 : r400_reg + R400_W'(1);
    assign r100_quad = (r100_reg == R100_W'(96))  ? '0 : r100_reg + R100_W'(4);
    assign r400_quad = (r400_reg == R400_W'(396)) ? '0 : r400_reg + R400_W'(4);

    always_comb
    begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        sel_next   = sel_reg;
        qy_next    = qy_reg;
        q100_next  = q100_reg;
        q400_next  = q400_reg;
        cnt_a_next = cnt_a_reg;
        cnt_b_next = cnt_b_reg;
        diff_next  = diff_reg;
        d_next     = d_reg;
        m_next     = m_reg;
        y_next     = y_reg;
        n_next     = n_reg;
        r4_next    = r4_reg;
        r100_next  = r100_reg;
        r400_next  = r400_reg;
        ovf_next   = ovf_reg;
        q_pop      = 1'b0;
        load_out   = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    sel_next   = 1'b0;
                    d_next     = q_cmd.first_day;
                    m_next     = q_cmd.first_month;
                    y_next     = q_cmd.first_year;
                    n_next     = q_cmd.days_to_add;
                    ovf_next   = 1'b0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                qy_next    = prod_y[RECIP_SHIFT +: Q_W];
                q100_next  = prod_99[RECIP_SHIFT +: Q_W];
                q400_next  = prod_399[RECIP_SHIFT + 2 +: Q400_W];
                state_next = (cmd_reg.action == ACT_ADD) ? ST_INIT : ST_CNT;
            end
            ST_CNT:
            begin
                if (!sel_reg)
                begin
                    cnt_a_next = count;
                    sel_next   = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    cnt_b_next = count;
                    state_next = ST_DIFF;
                end
            end
            ST_DIFF:
            begin
                diff_next  = (cnt_a_reg > cnt_b_reg) ? cnt_a_reg - cnt_b_reg
                                                     : cnt_b_reg - cnt_a_reg;
                state_next = ST_DONE;
            end
            ST_INIT:
            begin
                r4_next    = cur_y[1:0];
                r100_next  = y_mod100[R100_W-1:0];
                r400_next  = y_mod400[R400_W-1:0];
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (n_reg == '0)
                    state_next = ST_DONE;
                else if (at_jan1 && (r4_reg == 2'b00) && (y_reg <= MAX_QUAD_YEAR) &&
                         (n_reg >= ADD_W'(quad_len)))
                begin
                    // four whole years from a year divisible by four
                    n_next    = n_reg - ADD_W'(quad_len);
                    y_next    = y_reg + YEAR_W'(4);
                    r100_next = r100_quad;
                    r400_next = r400_quad;
                end
                else if (at_jan1 && (y_reg < MAX_YEAR) && (n_reg >= ADD_W'(year_len)))
                begin
                    n_next    = n_reg - ADD_W'(year_len);
                    y_next    = y_reg + YEAR_W'(1);
                    r4_next   = r4_reg + 2'b01;
                    r100_next = r100_inc;
                    r400_next = r400_inc;
                end
                else if (n_reg < ADD_W'(steps))
                begin
                    d_next = d_reg + n_reg[DAY_W-1:0];
                    n_next = '0;
                end
                else
                begin
                    n_next = n_reg - ADD_W'(steps);
                    d_next = DAY_W'(1);
                    if (m_reg == MONTH_DEC)
                    begin
                        m_next = MONTH_JAN;
                        if (y_reg >= MAX_YEAR)
                        begin
                            // past the last year: pin to its final day
                            ovf_next   = 1'b1;
                            d_next     = LAST_DAY_DEC;
                            m_next     = MONTH_DEC;
                            y_next     = MAX_YEAR;
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            y_next    = y_reg + YEAR_W'(1);
                            r4_next   = r4_reg + 2'b01;
                            r100_next = r100_inc;
                            r400_next = r400_inc;
                        end
                    end
                    else
                        m_next = m_reg + MON_W'(1);
                end
            end
            ST_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        rsp_valid_next = rsp_valid_reg;
        if (load_out)
            rsp_valid_next = 1'b1;
        else if (rsp.ready)
            rsp_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        sel_reg   <= sel_next;
        qy_reg    <= qy_next;
        q100_reg  <= q100_next;
        q400_reg  <= q400_next;
        cnt_a_reg <= cnt_a_next;
        cnt_b_reg <= cnt_b_next;
        diff_reg  <= diff_next;
        d_reg     <= d_next;
        m_reg     <= m_next;
        y_reg     <= y_next;
        n_reg     <= n_next;
        r4_reg    <= r4_next;
        r100_reg  <= r100_next;
        r400_reg  <= r400_next;
        ovf_reg   <= ovf_next;
        if (load_out)
        begin
            if (cmd_reg.action == ACT_ADD)
            begin
                out_diff_reg <= '0;
                out_day_reg  <= d_reg;
                out_mon_reg  <= m_reg;
                out_year_reg <= y_reg;
                out_ovf_reg  <= ovf_reg;
            end
            else
            begin
                out_diff_reg <= diff_reg;
                out_day_reg  <= '0;
                out_mon_reg  <= '0;
                out_year_reg <= '0;
                out_ovf_reg  <= 1'b0;
            end
        end
    end

    assign rsp.valid          = rsp_valid_reg;
    assign rsp.day_difference = out_diff_reg;
    assign rsp.result_day     = out_day_reg;
    assign rsp.result_month   = out_mon_reg;
    assign rsp.result_year    = out_year_reg;
    assign rsp.year_overflow  = out_ovf_reg;
endmodule

// ----- tb/gregorian_date_difference_add_tb.sv -----
// Testbench for the Gregorian date difference / add-days block: directed and random beats.
module gregorian_date_difference_add_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gdda_pkg::*;

    // Nothing accepted on either channel for this many cycles means a hang.
    // It is many times the worst case of the slowest add walk, the longest
    // receiver stall and the longest sender gap.
    localparam int IDLE_LIMIT  = 2000;
    // Cycles to keep watching after the last result, for stray beats.
    localparam int DRAIN_CYCLES = 150;
    localparam int PRINT_CAP    = 40;

    // One expected response beat.
    typedef struct packed {
        logic [DIFF_W-1:0] day_difference;
        logic [DAY_W-1:0]  result_day;
        logic [MON_W-1:0]  result_month;
        logic [YEAR_W-1:0] result_year;
        logic              year_overflow;
    } date_result_t;

    logic clk;
    logic rst_n;

    gdda_req_if req_ch ();
    gdda_rsp_if rsp_ch ();

    gregorian_date_difference_add u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    date_result_t expected_results[$];

    int n_errors    = 0;
    int n_sent      = 0;
    int n_checked   = 0;
    int n_diff_seen = 0;
    int n_add_seen  = 0;
    int n_ovf_seen  = 0;
    int burst_left  = 0;
    int idle_cycles = 0;

    // receiver stall pattern state
    int stall_mode    = 0;
    int stretch_left  = 0;
    int hold_left     = 0;

    initial clk = 1'b0;
    always #5 clk = ~clk;

    //------------------------------------------------------------------
    // Calendar predictor
    //------------------------------------------------------------------

    // Gregorian rule; year 0 is leap.
    function automatic bit leap_year(input int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned days_in_month(input int unsigned m, input int unsigned y);
        if (m == 4 || m == 6 || m == 9 || m == 11)
            return 30;
        if (m == 2)
            return leap_year(y) ? 29 : 28;
        return 31;
    endfunction

    function automatic int unsigned clamp_month(input logic [MON_W-1:0] m);
        if (m == 0)
            return 1;
        if (m > 12)
            return 12;
        return m;
    endfunction

    function automatic int unsigned clamp_year(input logic [YEAR_W-1:0] y);
        return (y > 9999) ? 9999 : y;
    endfunction

    // Day number counted from year 0: years before, months before, day as given.
    function automatic longint unsigned days_since_epoch(input int unsigned d,
                                                         input int unsigned m,
                                                         input int unsigned y);
        longint unsigned leaps;
        longint unsigned total;
        leaps = (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        total = longint'(y) * 365 + leaps;
        for (int unsigned i = 1; i < m; i++)
            total += days_in_month(i, y);
        return total + d;
    endfunction

    function automatic date_result_t predict_result(input cmd_t c);
        date_result_t    r;
        longint unsigned a;
        longint unsigned b;
        longint unsigned diff;
        int unsigned     d;
        int unsigned     m;
        int unsigned     y;
        int unsigned     n;
        int unsigned     len;
        int unsigned     steps;
        bit              ovf;
        r   = '0;
        ovf = 1'b0;
        d   = c.first_day;
        m   = clamp_month(c.first_month);
        y   = clamp_year(c.first_year);
        if (c.action == ACT_DIFF) begin
            a = days_since_epoch(d, m, y);
            b = days_since_epoch(c.second_day, clamp_month(c.second_month),
                                 clamp_year(c.second_year));
            diff = (a > b) ? a - b : b - a;
            if (diff > 64'h3F_FFFF)
                diff = 64'h3F_FFFF;
            r.day_difference = diff[DIFF_W-1:0];
        end
        else begin
            n = c.days_to_add;
            // jump a month at a time; a day past the month end rolls to the 1st
            while (n > 0) begin
                len   = days_in_month(m, y);
                steps = ((len > d) ? (len - d) : 0) + 1;
                if (n < steps) begin
                    d += n;
                    n = 0;
                end
                else begin
                    n -= steps;
                    d = 1;
                    m++;
                    if (m > 12) begin
                        m = 1;
                        if (y >= 9999) begin
                            ovf = 1'b1;
                            break;
                        end
                        y++;
                    end
                end
            end
            if (ovf) begin
                d = 31;
                m = 12;
                y = 9999;
            end
            r.result_day    = d[DAY_W-1:0];
            r.result_month  = m[MON_W-1:0];
            r.result_year   = y[YEAR_W-1:0];
            r.year_overflow = ovf;
        end
        return r;
    endfunction

    //------------------------------------------------------------------
    // Stimulus helpers
    //------------------------------------------------------------------

    function automatic cmd_t mk_cmd(input action_t act,
                                    input int unsigned d1, input int unsigned m1,
                                    input int unsigned y1,
                                    input int unsigned d2, input int unsigned m2,
                                    input int unsigned y2,
                                    input int unsigned n);
        cmd_t c;
        c.action       = act;
        c.first_day    = d1[DAY_W-1:0];
        c.first_month  = m1[MON_W-1:0];
        c.first_year   = y1[YEAR_W-1:0];
        c.second_day   = d2[DAY_W-1:0];
        c.second_month = m2[MON_W-1:0];
        c.second_year  = y2[YEAR_W-1:0];
        c.days_to_add  = n[ADD_W-1:0];
        return c;
    endfunction

    // Legal date, biased toward month ends, century years, the top years and years 0 to 8.
    task automatic rand_date(output int unsigned d, output int unsigned m,
                             output int unsigned y);
        int unsigned pick;
        int unsigned len;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            y = $urandom_range(0, 9999);
        else if (pick < 75)
            y = $urandom_range(0, 99) * 100;
        else if (pick < 90)
            y = $urandom_range(9980, 9999);
        else
            y = $urandom_range(0, 8);
        m    = $urandom_range(1, 12);
        len  = days_in_month(m, y);
        pick = $urandom_range(0, 9);
        if (pick < 5)
            d = $urandom_range(1, len);
        else if (pick < 8)
            d = $urandom_range(len - 2, len);
        else
            d = $urandom_range(1, 3);
    endtask

    // Sender: bursts of back-to-back beats separated by idle gaps.
    task automatic send_beat(input cmd_t c);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 8);
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 10);
        end
        burst_left--;
        req_ch.action       <= c.action;
        req_ch.first_day    <= c.first_day;
        req_ch.first_month  <= c.first_month;
        req_ch.first_year   <= c.first_year;
        req_ch.second_day   <= c.second_day;
        req_ch.second_month <= c.second_month;
        req_ch.second_year  <= c.second_year;
        req_ch.days_to_add  <= c.days_to_add;
        req_ch.valid        <= 1'b1;
        do
            @(posedge clk);
        while (!req_ch.ready);
        expected_results.push_back(predict_result(c));
        n_sent++;
        @(negedge clk);
    endtask

    task automatic report_mismatch(input string field, input int idx,
                                   input logic [31:0] got, input logic [31:0] want);
        n_errors++;
        if (n_errors <= PRINT_CAP)
            $display("mismatch beat %0d %s: got %0h want %0h", idx, field, got, want);
    endtask

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    task automatic test_directed_difference();
        // same date, then the widest span
        send_beat(mk_cmd(ACT_DIFF, 1, 1, 0, 1, 1, 0, 16'hFFFF));
        send_beat(mk_cmd(ACT_DIFF, 1, 1, 0, 31, 12, 9999, 0));
        send_beat(mk_cmd(ACT_DIFF, 31, 12, 9999, 1, 1, 0, 0));
        // day 0 used as given; month 0, year and month above range are clamped
        send_beat(mk_cmd(ACT_DIFF, 0, 0, 0, 31, 15, 16383, 1234));
        // leap day of a 400 year and a plain century; day 29 used as given in 1900
        send_beat(mk_cmd(ACT_DIFF, 29, 2, 2000, 1, 3, 2000, 0));
        send_beat(mk_cmd(ACT_DIFF, 29, 2, 1900, 1, 3, 1900, 0));
        send_beat(mk_cmd(ACT_DIFF, 28, 2, 2100, 1, 3, 2101, 0));
        // day past month end
        send_beat(mk_cmd(ACT_DIFF, 31, 4, 2023, 1, 5, 2023, 0));
        send_beat(mk_cmd(ACT_DIFF, 31, 12, 1999, 1, 1, 2000, 0));
        send_beat(mk_cmd(ACT_DIFF, 1, 3, 0, 28, 2, 0, 0));
    endtask

    task automatic test_directed_add();
        send_beat(mk_cmd(ACT_ADD, 15, 6, 2024, 31, 15, 16383, 0));
        send_beat(mk_cmd(ACT_ADD, 31, 12, 9998, 0, 0, 0, 1));
        // one day past the last year
        send_beat(mk_cmd(ACT_ADD, 31, 12, 9999, 0, 0, 0, 1));
        send_beat(mk_cmd(ACT_ADD, 1, 1, 0, 0, 0, 0, 16'hFFFF));
        send_beat(mk_cmd(ACT_ADD, 1, 1, 9999, 0, 0, 0, 16'hFFFF));
        // day 0 rolls to day 1 after one day
        send_beat(mk_cmd(ACT_ADD, 0, 3, 2020, 0, 0, 0, 1));
        send_beat(mk_cmd(ACT_ADD, 28, 2, 1900, 0, 0, 0, 1));
        send_beat(mk_cmd(ACT_ADD, 28, 2, 2000, 0, 0, 0, 1));
        send_beat(mk_cmd(ACT_ADD, 29, 2, 2004, 0, 0, 0, 365));
        // day beyond month end, clamped month and year
        send_beat(mk_cmd(ACT_ADD, 31, 2, 2001, 0, 0, 0, 1));
        send_beat(mk_cmd(ACT_ADD, 31, 0, 2001, 0, 0, 0, 31));
        send_beat(mk_cmd(ACT_ADD, 30, 13, 16383, 0, 0, 0, 1));
    endtask

    task automatic test_random_difference(input int count);
        int unsigned d1, m1, y1, d2, m2, y2;
        int unsigned pick;
        for (int i = 0; i < count; i++) begin
            rand_date(d1, m1, y1);
            rand_date(d2, m2, y2);
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
                d2 = d1;
                m2 = m1;
                y2 = y1;
            end
            else if (pick < 3)
                y2 = y1;
            send_beat(mk_cmd(ACT_DIFF, d1, m1, y1, d2, m2, y2, $urandom_range(0, 65535)));
        end
    endtask

    task automatic test_random_add(input int count);
        int unsigned d, m, y, n;
        int unsigned pick;
        for (int i = 0; i < count; i++) begin
            rand_date(d, m, y);
            pick = $urandom_range(0, 9);
            if (pick < 4)
                n = $urandom_range(0, 40);
            else if (pick < 7)
                n = $urandom_range(0, 800);
            else if (pick < 9)
                n = $urandom_range(0, 65535);
            else
                // land on the month end or just past it
                n = days_in_month(m, y) - d + $urandom_range(0, 1);
            send_beat(mk_cmd(ACT_ADD, d, m, y, $urandom_range(0, 31), $urandom_range(0, 15),
                             $urandom_range(0, 16383), n));
        end
    endtask

    task automatic test_random_overflow(input int count);
        int unsigned d, m, y, n;
        for (int i = 0; i < count; i++) begin
            rand_date(d, m, y);
            if ($urandom_range(0, 4) == 0)
                y = $urandom_range(10000, 16383);
            else
                y = $urandom_range(9800, 9999);
            if (d > days_in_month(m, clamp_year(y)))
                d = days_in_month(m, clamp_year(y));
            n = ($urandom_range(0, 1) == 0) ? $urandom_range(40000, 65535)
                                            : $urandom_range(0, 800);
            send_beat(mk_cmd(ACT_ADD, d, m, y, 0, 0, 0, n));
        end
    endtask

    // Unconstrained fields: out-of-range months, years and days everywhere.
    task automatic test_random_raw(input int count);
        for (int i = 0; i < count; i++)
            send_beat(mk_cmd(action_t'($urandom_range(0, 1)),
                             $urandom_range(0, 31), $urandom_range(0, 15),
                             $urandom_range(0, 16383),
                             $urandom_range(0, 31), $urandom_range(0, 15),
                             $urandom_range(0, 16383),
                             $urandom_range(0, 65535)));
    endtask

    //------------------------------------------------------------------
    // Receiver: ready changes at the falling edge, in stretches of three
    // kinds: always ready, coin flip each cycle, mostly ready with long holds.
    //------------------------------------------------------------------
    always @(negedge clk) begin
        logic rdy;
        if (stretch_left == 0) begin
            stall_mode   = $urandom_range(0, 2);
            stretch_left = $urandom_range(16, 64);
        end
        stretch_left--;
        case (stall_mode)
            0: rdy = 1'b1;
            1: rdy = $urandom_range(0, 1);
            default: begin
                if (hold_left > 0) begin
                    hold_left--;
                    rdy = 1'b0;
                end
                else if ($urandom_range(0, 9) == 0) begin
                    hold_left = $urandom_range(4, 24);
                    rdy = 1'b0;
                end
                else
                    rdy = 1'b1;
            end
        endcase
        rsp_ch.ready <= rdy;
    end

    //------------------------------------------------------------------
    // Result checker and watchdog. Sampled at the rising edge, so the
    // values seen are the ones the block presented before the edge.
    //------------------------------------------------------------------
    always @(posedge clk) begin
        date_result_t want;
        if (rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_results.size() == 0)
                    report_mismatch("unexpected beat", n_checked, 32'(rsp_ch.day_difference), 0);
                else begin
                    want = expected_results.pop_front();
                    if (rsp_ch.day_difference !== want.day_difference)
                        report_mismatch("day_difference", n_checked,
                                        32'(rsp_ch.day_difference), 32'(want.day_difference));
                    if (rsp_ch.result_day !== want.result_day)
                        report_mismatch("result_day", n_checked,
                                        32'(rsp_ch.result_day), 32'(want.result_day));
                    if (rsp_ch.result_month !== want.result_month)
                        report_mismatch("result_month", n_checked,
                                        32'(rsp_ch.result_month), 32'(want.result_month));
                    if (rsp_ch.result_year !== want.result_year)
                        report_mismatch("result_year", n_checked,
                                        32'(rsp_ch.result_year), 32'(want.result_year));
                    if (rsp_ch.year_overflow !== want.year_overflow)
                        report_mismatch("year_overflow", n_checked,
                                        32'(rsp_ch.year_overflow), 32'(want.year_overflow));
                    // a difference beat has the date fields at zero
                    if (want.result_month == 0)
                        n_diff_seen++;
                    else
                        n_add_seen++;
                    if (want.year_overflow)
                        n_ovf_seen++;
                end
                n_checked++;
            end
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         IDLE_LIMIT, expected_results.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    //------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------
    initial begin
        rst_n               = 1'b0;
        req_ch.valid        = 1'b0;
        req_ch.action       = ACT_DIFF;
        req_ch.first_day    = '0;
        req_ch.first_month  = '0;
        req_ch.first_year   = '0;
        req_ch.second_day   = '0;
        req_ch.second_month = '0;
        req_ch.second_year  = '0;
        req_ch.days_to_add  = '0;
        rsp_ch.ready        = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_directed_difference();
        test_directed_add();
        test_random_difference(550);
        test_random_add(850);
        test_random_overflow(100);
        test_random_raw(350);
        req_ch.valid <= 1'b0;

        // all beats accepted: wait out the outstanding results, then watch
        // a while longer for anything stray
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d request beats: %0d differences, %0d adds (%0d past year 9999)",
                 n_sent, n_diff_seen, n_add_seen, n_ovf_seen);
        $display("results checked %0d, mismatches %0d", n_checked, n_errors);
        if (n_errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
